@@ sv/allow_deny_id_table_macros.svh @@
// Assertion macros for the allow/deny ID table.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ALLOW_DENY_ID_TABLE_MACROS_SVH
`define ALLOW_DENY_ID_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising aclk edge outside reset.
`define ADL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Check a property on every rising aclk edge, reset included.
`define ADL_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);

`else

`define ADL_ASSERT(lbl, prop, msg)
`define ADL_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ sv/adl_pkg.sv @@
// Shared types, operation codes and helpers for the allow/deny ID table.
// No dependencies; imported by adl_list and allow_deny_id_table.
package adl_pkg;

    localparam int TABLE_DEPTH = 8;
    localparam int ID_BITS     = 32;
    localparam int DEV_ID_W    = 32;
    localparam int MODE_W      = 3;
    localparam int CLASS_W     = 2;
    localparam int S_TDATA_W   = 40;
    localparam int M_TDATA_W   = 8;

    localparam logic [MODE_W-1:0] OP_ADD_ALLOW = 3'd0;
    localparam logic [MODE_W-1:0] OP_REM_ALLOW = 3'd1;
    localparam logic [MODE_W-1:0] OP_ADD_DENY  = 3'd2;
    localparam logic [MODE_W-1:0] OP_REM_DENY  = 3'd3;
    localparam logic [MODE_W-1:0] OP_CLASSIFY  = 3'd4;

    localparam logic [CLASS_W-1:0] CLASS_NONE  = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_ALLOW = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_DENY  = 2'd2;

    typedef logic [ID_BITS-1:0]     id_t;
    typedef logic [TABLE_DEPTH-1:0] slot_vec_t;

    // One update to a list: write the slot(s) in slot with the ID, or clear them.
    typedef struct packed {
        logic      we;
        logic      clr;
        slot_vec_t slot;
    } list_upd_t;

    // Keep only the lowest set bit.
    function automatic slot_vec_t lowest_bit(input slot_vec_t v);
        return v & (~v + 1'b1);
    endfunction

endpackage

@@ sv/allow_deny_id_table.sv @@
// Top level of the allow/deny ID table: input register, list update, result register.
// Depends on adl_pkg, adl_list and allow_deny_id_table_macros.svh.
//
//  channel | direction | tdata bits (low to high)             | width
//  s_      | in        | mode[2:0], device_id[34:3], zero pad  | 40
//  m_      | out       | ok[0], id_class[2:1], zero pad        | 8
//
// One transaction per cycle sustained while m_ is not stalled; a result is presented on m_
// after its input transaction passes the input register, then the result register.
// The list compare and update finish in the cycle a transaction leaves the
// input register, so the next one sees the updated lists.
// Reset (aresetn low, synchronous) empties both lists and drops held transactions.
// A stall on m_ backs up into the input register and then drops s_tready.
`include "allow_deny_id_table_macros.svh"

module allow_deny_id_table import adl_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // mode[2:0], device_id[34:3]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // ok[0], id_class[2:1]
);

    logic                 in_valid_reg;
    logic [MODE_W-1:0]    in_mode_reg;
    id_t                  in_id_reg;
    logic                 m_valid_reg;
    logic                 m_ok_reg;
    logic [CLASS_W-1:0]   m_class_reg;

    logic                 out_ready;
    logic                 fire;
    logic                 id_nz;
    slot_vec_t            a_hit, a_free, d_hit, d_free;
    slot_vec_t            a_new, d_new, first;
    list_upd_t            a_upd, d_upd;
    logic                 ok_next;
    logic [CLASS_W-1:0]   class_next;
    logic                 add_allow_fire;
    logic                 list_wr;

    assign out_ready = !m_valid_reg || m_tready;
    assign fire      = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign id_nz     = |in_id_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_mode_reg <= s_tdata[MODE_W-1:0];
            in_id_reg   <= ID_BITS'(s_tdata[MODE_W +: DEV_ID_W]);
        end
    end

    adl_list u_allow (
        .aclk    (aclk),
        .aresetn (aresetn),
        .id      (in_id_reg),
        .upd     (a_upd),
        .hit     (a_hit),
        .free    (a_free)
    );

    adl_list u_deny (
        .aclk    (aclk),
        .aresetn (aresetn),
        .id      (in_id_reg),
        .upd     (d_upd),
        .hit     (d_hit),
        .free    (d_free)
    );

    always_comb begin
        a_upd   = '0;
        d_upd   = '0;
        a_new   = a_hit;
        d_new   = d_hit;
        ok_next = 1'b0;
        unique case (in_mode_reg)
            OP_ADD_ALLOW: begin
                if (id_nz && !(|d_hit) && (|a_free)) begin
                    ok_next    = 1'b1;
                    a_upd.slot = lowest_bit(a_free);
                    a_new      = a_hit | a_upd.slot;
                end
            end
            OP_REM_ALLOW: begin
                if (id_nz && (|a_hit)) begin
                    ok_next    = 1'b1;
                    a_upd.clr  = 1'b1;
                    a_upd.slot = lowest_bit(a_hit);
                    a_new      = a_hit & ~a_upd.slot;
                end
            end
            OP_ADD_DENY: begin
                if (id_nz && !(|a_hit) && (|d_free)) begin
                    ok_next    = 1'b1;
                    d_upd.slot = lowest_bit(d_free);
                    d_new      = d_hit | d_upd.slot;
                end
            end
            OP_REM_DENY: begin
                if (id_nz && (|d_hit)) begin
                    ok_next    = 1'b1;
                    d_upd.clr  = 1'b1;
                    d_upd.slot = lowest_bit(d_hit);
                    d_new      = d_hit & ~d_upd.slot;
                end
            end
            OP_CLASSIFY: begin
                ok_next = id_nz;
            end
            default: begin
                ok_next = 1'b0;
            end
        endcase
        // commit only when the transaction moves on to the result register
        a_upd.we = fire && ok_next && (|a_upd.slot);
        d_upd.we = fire && ok_next && (|d_upd.slot);

        // class after the update: lowest matching slot, allow wins a tie
        first = lowest_bit(a_new | d_new);
        if (!id_nz) begin
            class_next = CLASS_NONE;
        end else if (|(first & a_new)) begin
            class_next = CLASS_ALLOW;
        end else if (|(first & d_new)) begin
            class_next = CLASS_DENY;
        end else begin
            class_next = CLASS_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            m_ok_reg    <= ok_next;
            m_class_reg <= class_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - CLASS_W - 1){1'b0}}, m_class_reg, m_ok_reg};

    assign add_allow_fire = fire && ok_next && (in_mode_reg == OP_ADD_ALLOW);
    assign list_wr        = a_upd.we || d_upd.we;

    `ADL_ASSERT(a_lists_disjoint, (in_valid_reg && id_nz) |-> !(|a_hit && |d_hit), "ID on both")
    `ADL_ASSERT(a_class_legal, m_valid_reg |-> (m_class_reg != 2'd3), "illegal class code")
    `ADL_ASSERT(a_out_source, $rose(m_valid_reg) |-> $past(in_valid_reg), "result without input")
    `ADL_ASSERT(a_add_class, add_allow_fire |=> (m_class_reg == CLASS_ALLOW), "add not classed allow")
    `ADL_ASSERT_ALWAYS(a_no_write_idle, !in_valid_reg |-> !list_wr, "list write when idle")

endmodule

@@ sv/adl_list.sv @@
// One ID list: register table with parallel compare against a lookup ID.
// Depends on adl_pkg for the table geometry and the update struct.
module adl_list import adl_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  id_t       id,
    input  list_upd_t upd,
    output slot_vec_t hit,
    output slot_vec_t free
);

    id_t ids_reg [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                ids_reg[i] <= '0;
            end
        end else if (upd.we) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                if (upd.slot[i]) begin
                    ids_reg[i] <= upd.clr ? '0 : id;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            hit[i]  = (ids_reg[i] == id);
            free[i] = (ids_reg[i] == '0);
        end
    end

endmodule
